// ----- rtl/msp_pkg.sv -----
// ============================================================================
// msp_pkg
// Shared types, constants and helper functions of the Mandelbrot pixel
// coloring block: controller states, command and status groups, saturating
// arithmetic and the sine palette contents.
// ============================================================================
package msp_pkg;

    // Sizing of the iteration loop and of the palette.
    localparam int MAX_ITERATIONS = 1000;
    localparam int PALETTE_SIZE   = 500;
    localparam int PERIOD_LEN     = 9;

    // Count holds up to the cap plus the two extra steps and the correction.
    localparam int CNT_W  = $clog2(MAX_ITERATIONS + 4);
    localparam int PAL_AW = $clog2(PALETTE_SIZE);
    localparam int NUM_W  = CNT_W + $clog2(PALETTE_SIZE + 1);
    localparam int MU_W   = CNT_W + 26;
    localparam int LOG_W  = 30;
    localparam int RGB_W  = 24;

    // Reciprocal of the iteration cap, exact for every numerator of NUM_W bits.
    localparam int DIV_SHIFT = NUM_W + $clog2(MAX_ITERATIONS);
    localparam logic [NUM_W:0] DIV_RECIP =
        (NUM_W + 1)'(((64'd1 << DIV_SHIFT) + 64'(MAX_ITERATIONS) - 64'd1)
                     / 64'(MAX_ITERATIONS));

    // Fixed point constants.
    localparam logic signed [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] INT64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] FOUR_Q40  = 64'sd4 <<< 40;
    localparam logic [LOG_W-1:0]   LOG_41    = LOG_W'(41) << 24;
    localparam logic [LOG_W-1:0]   LOG_40    = LOG_W'(40) << 24;
    localparam logic [LOG_W-1:0]   LOG_24    = LOG_W'(24) << 24;
    localparam logic [LOG_W-1:0]   LOG_ONE   = LOG_W'(1) << 24;
    localparam logic [MU_W-1:0]    LOG_C     = MU_W'(8871228);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_START_REAL = 2'd0,
        REG_TOP_IMAG   = 2'd1,
        REG_STEP_REAL  = 2'd2,
        REG_STEP_IMAG  = 2'd3
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_FILL,
        ST_IDLE,
        ST_CMUL,
        ST_CADD,
        ST_MXY,
        ST_WXY,
        ST_UPD,
        ST_MXX,
        ST_WXX,
        ST_MYY,
        ST_WYY,
        ST_CHK,
        ST_LOG1,
        ST_WLOG1,
        ST_LOG2,
        ST_WLOG2,
        ST_MU,
        ST_DIVI,
        ST_DIV,
        ST_PAL,
        ST_LOAD
    } state_t;

    // Log unit sequencer states.
    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ
    } log_state_t;

    // Operand pairs of the fixed point multiplier.
    typedef enum logic [1:0] {
        MUL_XY,
        MUL_XX,
        MUL_YY
    } mul_sel_t;

    // Operand of the log unit.
    typedef enum logic {
        LOG_SUM,
        LOG_L1
    } log_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     fill_we;
        logic     c_mul;
        logic     c_add;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     upd_zc;
        logic     step_upd;
        logic     set_inside;
        logic     count_inc;
        logic     log_start;
        log_sel_t log_sel;
        logic     mu_calc;
        logic     div_init;
        logic     div_step;
        logic     pal_read;
        logic     out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic mul_done;
        logic log_done;
        logic cycle_hit;
        logic escaped;
        logic cap_hit;
        logic is_inside;
        logic out_busy;
    } dp_status_t;

    // Sum clamped to the signed 64 bit range.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            s = a[63] ? INT64_MIN : INT64_MAX;
        end
        return s;
    endfunction

    // Difference clamped to the signed 64 bit range.
    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            s = a[63] ? INT64_MIN : INT64_MAX;
        end
        return s;
    endfunction

    // Clamp a 46 bit value to the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] r;
        if (v > 46'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -46'sh0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Palette generation, evaluated at elaboration only.
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned PIHALF_Q30  = 64'd1686629713;
    localparam longint unsigned PAL_PERIOD  = 64'(12 * PALETTE_SIZE);
    localparam longint unsigned PAL_QUARTER = 64'(3 * PALETTE_SIZE);

    typedef logic [RGB_W-1:0] palette_t [PALETTE_SIZE];

    // Sine of one palette phase in Q30, odd Taylor series in nested form.
    function automatic longint sine_q30(input longint unsigned q_in);
        longint unsigned q, quad, rem, r, x, x2, t, s;
        q    = q_in % PAL_PERIOD;
        quad = q / PAL_QUARTER;
        rem  = q % PAL_QUARTER;
        r    = quad[0] ? PAL_QUARTER - rem : rem;
        if (r == 0) begin
            s = 0;
        end else if (r == PAL_QUARTER) begin
            s = Q30_ONE;
        end else begin
            x  = (r * PIHALF_Q30) / PAL_QUARTER;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 156;
            t  = Q30_ONE - ((x2 * t) >> 30) / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            if (s > Q30_ONE) begin
                s = Q30_ONE;
            end
        end
        return (quad >= 2) ? -longint'(s) : longint'(s);
    endfunction

    // One 8 bit color channel, phase advanced by k thirds of a turn.
    function automatic logic [7:0] pal_chan(input longint unsigned i,
                                            input longint unsigned k);
        longint s, v;
        s = sine_q30(64'd12 * i + 64'd4 * k * 64'(PALETTE_SIZE));
        v = s * 127 + (longint'(128) <<< 30);
        return 8'(v >>> 30);
    endfunction

    function automatic palette_t build_palette();
        palette_t pal;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            pal[i] = {pal_chan(64'(i), 64'd1), pal_chan(64'(i), 64'd0),
                      pal_chan(64'(i), 64'd2)};
        end
        return pal;
    endfunction

    localparam palette_t PALETTE = build_palette();

endpackage

// ----- rtl/msp_ram.sv -----
// ============================================================================
// msp_ram
// Generic single write port RAM with one registered read port.
// ============================================================================
module msp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 500,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/msp_qmul.sv -----
// ============================================================================
// msp_qmul
// Q23.40 multiplier: magnitude product from four 32x32 partial products,
// truncated toward zero and saturated symmetrically.
// ============================================================================
module msp_qmul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] result
);
    import msp_pkg::*;

    logic               busy_reg;
    logic [2:0]         cnt_reg;
    logic               done_reg;
    logic [63:0]        ua_reg;
    logic [63:0]        ub_reg;
    logic               neg_reg;
    logic [63:0]        pp_reg;
    logic [1:0]         pp_sel_reg;
    logic [127:0]       acc_reg;
    logic signed [63:0] res_reg;

    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [127:0]       pp_shifted;
    logic [63:0]        mag;
    logic signed [63:0] res_next;

    // Partial product order: low-low, low-high, high-low, high-high.
    assign op_a = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign op_b = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];

    always_comb begin
        case (pp_sel_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
    end

    // Saturate on any bit above the Q23.40 range, then apply the sign.
    always_comb begin
        if (|acc_reg[127:103]) begin
            mag = {1'b0, {63{1'b1}}};
        end else begin
            mag = {1'b0, acc_reg[102:40]};
        end
        res_next = neg_reg ? -$signed(mag) : $signed(mag);
    end

    // Sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // Operands, partial products and accumulation.
    always_ff @(posedge aclk) begin
        if (start) begin
            ua_reg  <= a[63] ? 64'(-a) : 64'(a);
            ub_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] != b[63];
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg <= 3'd3) begin
                pp_reg     <= 64'(op_a) * 64'(op_b);
                pp_sel_reg <= cnt_reg[1:0];
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                acc_reg <= acc_reg + pp_shifted;
            end
            if (cnt_reg == 3'd5) begin
                res_reg <= res_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/msp_log2.sv -----
// ============================================================================
// msp_log2
// Fixed point log2 with 24 fraction bits: leading one search one bit per
// cycle, then one squaring per fraction bit.
// ============================================================================
module msp_log2 (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [63:0]               value,
    output logic                      done,
    output logic [msp_pkg::LOG_W-1:0] result
);
    import msp_pkg::*;

    log_state_t  state_reg;
    logic        done_reg;
    logic [63:0] v_reg;
    logic [5:0]  k_reg;
    logic [30:0] t_reg;
    logic [23:0] frac_reg;
    logic [4:0]  i_reg;

    logic [61:0] sq;
    logic [31:0] t2;

    assign sq = 62'(t_reg) * 62'(t_reg);
    assign t2 = sq[61:30];

    // Control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LG_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end else begin
            case (state_reg)
                LG_IDLE: begin
                    if (start) begin
                        state_reg <= LG_NORM;
                        done_reg  <= 1'b0;
                    end
                end
                LG_NORM: begin
                    if (v_reg[63]) begin
                        state_reg <= LG_SQ;
                        i_reg     <= 5'd23;
                    end
                end
                LG_SQ: begin
                    if (i_reg == 5'd0) begin
                        state_reg <= LG_IDLE;
                        done_reg  <= 1'b1;
                    end
                    i_reg <= i_reg - 5'd1;
                end
                default: state_reg <= LG_IDLE;
            endcase
        end
    end

    // Normalization and squaring steps.
    always_ff @(posedge aclk) begin
        case (state_reg)
            LG_IDLE: begin
                if (start) begin
                    v_reg    <= (value == 64'd0) ? 64'd1 : value;
                    k_reg    <= 6'd63;
                    frac_reg <= '0;
                end
            end
            LG_NORM: begin
                if (v_reg[63]) begin
                    t_reg <= v_reg[63:33];
                end else begin
                    v_reg <= v_reg << 1;
                    k_reg <= k_reg - 6'd1;
                end
            end
            LG_SQ: begin
                if (t2[31]) begin
                    t_reg <= t2[31:1];
                end else begin
                    t_reg <= t2[30:0];
                end
                frac_reg <= {frac_reg[22:0], t2[31]};
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = {k_reg, frac_reg};

endmodule

// ----- rtl/msp_datapath.sv -----
// ============================================================================
// msp_datapath
// Configuration registers, orbit registers, multiplier and log units, the
// palette RAM and the output word register.
// ============================================================================
module msp_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  msp_pkg::ctrl_cmd_t  cmd,
    output msp_pkg::dp_status_t status,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [23:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic                m_tuser
);
    import msp_pkg::*;

    // Configuration.
    logic signed [31:0] start_real_reg;
    logic signed [31:0] top_imag_reg;
    logic signed [31:0] step_real_reg;
    logic signed [31:0] step_imag_reg;

    // Pixel and orbit state.
    logic [11:0]          col_reg;
    logic [11:0]          row_reg;
    logic signed [44:0]   prod_r_reg;
    logic signed [44:0]   prod_i_reg;
    logic signed [63:0]   cr_reg;
    logic signed [63:0]   ci_reg;
    logic signed [63:0]   x_reg;
    logic signed [63:0]   y_reg;
    logic signed [63:0]   x2_reg;
    logic signed [63:0]   y2_reg;
    logic signed [63:0]   lx_reg;
    logic signed [63:0]   ly_reg;
    logic signed [63:0]   p_reg;
    logic [3:0]           per_reg;
    logic [CNT_W-1:0]     count_reg;
    mul_sel_t             mul_sel_reg;

    // Palette index and fill.
    logic [NUM_W-1:0]     num_reg;
    logic [PAL_AW-1:0]    fill_idx_reg;

    // Output word.
    logic                 m_tvalid_reg;
    logic [9:0]           cnt_out_reg;
    logic                 inside_out_reg;
    logic [RGB_W-1:0]     rgb_out_reg;

    // Unit connections.
    logic signed [63:0]   mul_a;
    logic signed [63:0]   mul_b;
    logic                 mul_done;
    logic signed [63:0]   mul_res;
    logic [63:0]          log_in;
    logic                 log_done;
    logic [LOG_W-1:0]     log_res;
    logic [RGB_W-1:0]     pal_rdata;

    logic signed [63:0]   mag2;
    logic [LOG_W-1:0]     l1;
    logic [LOG_W-1:0]     l2;
    logic [CNT_W:0]       cnt1;
    logic signed [MU_W-1:0] mu_val;
    logic [2*NUM_W:0]     quot_full;
    logic [NUM_W-1:0]     pal_idx;
    logic [3:0]           per_inc;
    logic [CNT_W+9:0]     cnt_ext;
    logic signed [45:0]   sum_r;
    logic signed [45:0]   sum_i;
    logic signed [31:0]   c_r_sat;
    logic signed [31:0]   c_i_sat;
    logic                 inside_now;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_real_reg <= -32'sd536870912;
            top_imag_reg   <= 32'sd268435456;
            step_real_reg  <= 32'sd786432;
            step_imag_reg  <= 32'sd786432;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_START_REAL: start_real_reg <= cfg_data;
                REG_TOP_IMAG:   top_imag_reg   <= cfg_data;
                REG_STEP_REAL:  step_real_reg  <= cfg_data;
                REG_STEP_IMAG:  step_imag_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fixed point multiplier shared by the three products of an iteration.
    always_comb begin
        case (cmd.mul_sel)
            MUL_XX: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            MUL_YY: begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default: begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    msp_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    // Log unit: first on |z|^2, then on the shifted first result.
    assign mag2 = sat_add(x2_reg, y2_reg);
    assign l1   = (log_res < LOG_41) ? LOG_ONE : log_res - LOG_40;
    assign l2   = log_res - LOG_24;
    assign log_in = (cmd.log_sel == LOG_L1) ? {{(64 - LOG_W){1'b0}}, l1} : 64'(mag2);

    msp_log2 u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.log_start),
        .value   (log_in),
        .done    (log_done),
        .result  (log_res)
    );

    // Smoothed count: (n + 1) + C - log2(log2 |z|^2 - 40).
    assign cnt1   = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign mu_val = $signed({1'b0, cnt1, 24'd0}) + $signed(LOG_C)
                  - $signed({{(MU_W - LOG_W){1'b0}}, l2});

    // Division of count * PALETTE_SIZE by the iteration cap through a reciprocal.
    assign quot_full = (2 * NUM_W + 1)'(num_reg) * (2 * NUM_W + 1)'(DIV_RECIP);
    assign pal_idx   = (num_reg >= NUM_W'(PALETTE_SIZE)) ? num_reg - NUM_W'(PALETTE_SIZE)
                                                         : num_reg;

    // Palette RAM, loaded from the constant table after reset.
    msp_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .aclk  (aclk),
        .we    (cmd.fill_we),
        .waddr (fill_idx_reg),
        .wdata (PALETTE[fill_idx_reg]),
        .re    (cmd.pal_read),
        .raddr (pal_idx[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_idx_reg <= '0;
        end else if (cmd.fill_we) begin
            fill_idx_reg <= fill_idx_reg + PAL_AW'(1);
        end
    end

    // c from the pixel position, saturated to Q4.28 and widened to Q23.40.
    assign sum_r = $signed({{14{start_real_reg[31]}}, start_real_reg})
                 + $signed({prod_r_reg[44], prod_r_reg});
    assign sum_i = $signed({{14{top_imag_reg[31]}}, top_imag_reg})
                 - $signed({prod_i_reg[44], prod_i_reg});
    assign c_r_sat = sat32(sum_r);
    assign c_i_sat = sat32(sum_i);

    assign per_inc = per_reg + 4'd1;

    // Orbit registers and counters.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            col_reg   <= s_tdata[11:0];
            row_reg   <= s_tdata[23:12];
            x_reg     <= '0;
            y_reg     <= '0;
            x2_reg    <= '0;
            y2_reg    <= '0;
            lx_reg    <= '0;
            ly_reg    <= '0;
            per_reg   <= '0;
            count_reg <= '0;
        end
        if (cmd.c_mul) begin
            prod_r_reg <= $signed({1'b0, col_reg}) * step_real_reg;
            prod_i_reg <= $signed({1'b0, row_reg}) * step_imag_reg;
        end
        if (cmd.c_add) begin
            cr_reg <= {{20{c_r_sat[31]}}, c_r_sat, 12'd0};
            ci_reg <= {{20{c_i_sat[31]}}, c_i_sat, 12'd0};
        end
        if (cmd.mul_start) begin
            mul_sel_reg <= cmd.mul_sel;
        end
        if (mul_done) begin
            case (mul_sel_reg)
                MUL_XX:  x2_reg <= mul_res;
                MUL_YY:  y2_reg <= mul_res;
                default: p_reg  <= mul_res;
            endcase
        end
        if (cmd.upd_zc) begin
            y_reg <= sat_add(sat_add(p_reg, p_reg), ci_reg);
            x_reg <= sat_add(sat_sub(x2_reg, y2_reg), cr_reg);
        end
        if (cmd.step_upd) begin
            count_reg <= count_reg + CNT_W'(1);
            // Snapshot for the periodicity check every PERIOD_LEN steps.
            if (per_inc > 4'(PERIOD_LEN)) begin
                lx_reg  <= x_reg;
                ly_reg  <= y_reg;
                per_reg <= 4'd1;
            end else begin
                per_reg <= per_inc;
            end
        end
        if (cmd.count_inc) begin
            count_reg <= count_reg + CNT_W'(1);
        end
        if (cmd.set_inside) begin
            count_reg <= CNT_W'(MAX_ITERATIONS);
        end
        if (cmd.mu_calc) begin
            count_reg <= mu_val[MU_W-1] ? '0 : mu_val[CNT_W+23:24];
        end
        if (cmd.div_init) begin
            num_reg <= NUM_W'(count_reg) * NUM_W'(PALETTE_SIZE);
        end
        if (cmd.div_step) begin
            num_reg <= NUM_W'(quot_full >> DIV_SHIFT);
        end
    end

    // Output word register; a new word loads when the old one is taken.
    assign inside_now = count_reg == CNT_W'(MAX_ITERATIONS);
    assign cnt_ext    = {10'd0, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            cnt_out_reg    <= cnt_ext[9:0];
            inside_out_reg <= inside_now;
            rgb_out_reg    <= inside_now ? '0 : pal_rdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = inside_out_reg;
    assign m_tdata  = {6'd0, rgb_out_reg[7:0], rgb_out_reg[15:8], rgb_out_reg[23:16],
                       cnt_out_reg};

    // Status toward the controller.
    always_comb begin
        status.fill_last = fill_idx_reg == PAL_AW'(PALETTE_SIZE - 1);
        status.mul_done  = mul_done;
        status.log_done  = log_done;
        status.cycle_hit = (x_reg == lx_reg) && (y_reg == ly_reg);
        status.escaped   = mag2 > FOUR_Q40;
        status.cap_hit   = cnt1 == (CNT_W + 1)'(MAX_ITERATIONS);
        status.is_inside = inside_now;
        status.out_busy  = m_tvalid_reg && !m_tready;
    end

endmodule

// ----- rtl/msp_ctrl.sv -----
// ============================================================================
// msp_ctrl
// Controller: palette load after reset, pixel setup, escape loop, the two
// extra steps, log correction, palette lookup and output load.
// ============================================================================
module msp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  msp_pkg::dp_status_t status,
    output msp_pkg::ctrl_cmd_t  cmd
);
    import msp_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] extra_reg;
    logic [1:0] extra_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        extra_next = extra_reg;
        case (state_reg)
            ST_FILL:  if (status.fill_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CMUL;
                    extra_next = 2'd0;
                end
            end
            ST_CMUL:  state_next = ST_CADD;
            ST_CADD:  state_next = ST_MXY;
            ST_MXY:   state_next = ST_WXY;
            ST_WXY:   if (status.mul_done) state_next = ST_UPD;
            ST_UPD:   state_next = ST_MXX;
            ST_MXX:   state_next = ST_WXX;
            ST_WXX:   if (status.mul_done) state_next = ST_MYY;
            ST_MYY:   state_next = ST_WYY;
            ST_WYY:   if (status.mul_done) state_next = ST_CHK;
            ST_CHK: begin
                if (extra_reg == 2'd0) begin
                    // Main loop: orbit cycle or cap means inside.
                    if (status.cycle_hit || status.cap_hit) begin
                        state_next = ST_LOAD;
                    end else if (status.escaped) begin
                        state_next = ST_MXY;
                        extra_next = 2'd1;
                    end else begin
                        state_next = ST_MXY;
                    end
                end else if (extra_reg == 2'd2) begin
                    state_next = ST_LOG1;
                end else begin
                    state_next = ST_MXY;
                    extra_next = 2'd2;
                end
            end
            ST_LOG1:  state_next = ST_WLOG1;
            ST_WLOG1: if (status.log_done) state_next = ST_LOG2;
            ST_LOG2:  state_next = ST_WLOG2;
            ST_WLOG2: if (status.log_done) state_next = ST_MU;
            ST_MU:    state_next = ST_DIVI;
            ST_DIVI:  state_next = status.is_inside ? ST_LOAD : ST_DIV;
            ST_DIV:   state_next = ST_PAL;
            ST_PAL:   state_next = ST_LOAD;
            ST_LOAD:  if (!status.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_XY;
        cmd.log_sel = LOG_SUM;
        s_tready    = 1'b0;
        case (state_reg)
            ST_FILL: cmd.fill_we = 1'b1;
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_CMUL: cmd.c_mul = 1'b1;
            ST_CADD: cmd.c_add = 1'b1;
            ST_MXY: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_XY;
            end
            ST_UPD: cmd.upd_zc = 1'b1;
            ST_MXX: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_XX;
            end
            ST_MYY: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_YY;
            end
            ST_CHK: begin
                if (extra_reg != 2'd0) begin
                    cmd.count_inc = 1'b1;
                end else if (status.cycle_hit) begin
                    cmd.set_inside = 1'b1;
                end else begin
                    cmd.step_upd = 1'b1;
                end
            end
            ST_LOG1: begin
                cmd.log_start = 1'b1;
                cmd.log_sel   = LOG_SUM;
            end
            ST_LOG2: begin
                cmd.log_start = 1'b1;
                cmd.log_sel   = LOG_L1;
            end
            ST_MU:   cmd.mu_calc  = 1'b1;
            ST_DIVI: cmd.div_init = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_PAL:  cmd.pal_read = 1'b1;
            ST_LOAD: cmd.out_load = !status.out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            extra_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            extra_reg <= extra_next;
        end
    end

endmodule

// ----- rtl/mandelbrot_smooth_pixel_color.sv -----
// ============================================================================
// mandelbrot_smooth_pixel_color: escape time pixel with smoothed count and palette.
// After reset the palette RAM loads from the constant table; s_tready stays low meanwhile.
// Each escape loop step runs three products on one multiplier.
// An escaping pixel then takes two extra steps, the log steps, the palette lookup
// and the output load; a pixel found inside goes straight to the output load.
// The output word register frees the input side once a result is loaded.
// ============================================================================
module mandelbrot_smooth_pixel_color (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Pixel input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_column[11:0], pixel_row[23:12]
    // Color output words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // smooth_count[9:0], red[17:10], green[25:18],
                                   // blue[33:26], zero[39:34]
    output logic        m_tuser    // inside_set[0]
);
    import msp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    msp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the Mandelbrot smooth pixel color block. Pixel
// words go in through a queue-fed driver with random gaps. A monitor stalls
// the color stream at random and checks every color word against a local
// fixed point model of the escape loop, the log correction and the palette.
// ============================================================================
module tb_top;
    import msp_pkg::*;

    localparam int IDLE_LIMIT = 120000;
    localparam int LONG_HOLD  = 3000;

    // One expected color word.
    typedef struct {
        bit [9:0] count;
        bit       in_set;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
    } pix_color_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // pixel_column[11:0], pixel_row[23:12]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // smooth_count[9:0], red[17:10], green[25:18],
                                 // blue[33:26], zero[39:34]
    logic        m_tuser;        // inside_set[0]

    mandelbrot_smooth_pixel_color dut (.*);

    // Pixels waiting to be sent and colors waiting to arrive.
    bit [23:0]  pixel_q[$];
    pix_color_t color_q[$];
    bit [23:0]  hue_rom[PALETTE_SIZE];

    // Local copy of the view window registers.
    longint re_start = -536870912;
    longint im_top   = 268435456;
    longint re_step  = 786432;
    longint im_step  = 786432;

    bit s_fire = 0, m_fire = 0, quiet = 0, hold_armed = 0;
    int s_gap = 0, m_stall = 0, hold_cnt = 0, idle_cycles = 0, errors = 0;

    always #5 aclk = ~aclk;

    // ---------------- fixed point model ----------------

    function automatic longint sat_sum(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? INT64_MIN : INT64_MAX;
        return s;
    endfunction

    function automatic longint sat_diff(input longint a, input longint b);
        longint s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? INT64_MIN : INT64_MAX;
        return s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q23.40 product, truncated toward zero, magnitude saturated.
    function automatic longint q40_mul(input longint a, input longint b);
        bit [63:0]  ua, ub, r;
        bit [127:0] pr;
        ua = a < 0 ? 64'(-a) : 64'(a);
        ub = b < 0 ? 64'(-b) : 64'(b);
        pr = {64'd0, ua} * {64'd0, ub};
        if (pr[127:103] != '0) r = 64'h7FFF_FFFF_FFFF_FFFF;
        else r = pr[103:40];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // log2 with 24 fraction bits, one bit per squaring.
    function automatic longint unsigned log2_q24(input longint unsigned v);
        int k;
        longint unsigned t, frac;
        frac = 0;
        if (v == 0) v = 1;
        k = 63;
        while (v[k] == 1'b0) k--;
        t = k > 30 ? v >> (k - 30) : v << (30 - k);
        for (int i = 23; i >= 0; i--) begin
            t = (t * t) >> 30;
            if (t >= 64'd2147483648) begin
                t = t >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return (64'(k) << 24) | frac;
    endfunction

    // Sine of phase q over a period of 12 palette sizes, Q30.
    function automatic longint wave_q30(input longint unsigned q);
        longint unsigned per, qtr, quad, rem, r, x, x2, t, s;
        longint unsigned dens[6];
        dens = '{156, 110, 72, 42, 20, 6};
        per  = 12 * PALETTE_SIZE;
        qtr  = per / 4;
        q    = q % per;
        quad = q / qtr;
        rem  = q % qtr;
        r    = quad[0] ? qtr - rem : rem;
        if (r == 0) begin
            s = 0;
        end else if (r == qtr) begin
            s = 64'd1073741824;
        end else begin
            x  = (r * 64'd1686629713) / qtr;
            x2 = (x * x) >> 30;
            t  = 64'd1073741824;
            for (int i = 0; i < 6; i++) t = 64'd1073741824 - ((x2 * t) >> 30) / dens[i];
            s = (x * t) >> 30;
            if (s > 64'd1073741824) s = 64'd1073741824;
        end
        return quad >= 2 ? -longint'(s) : longint'(s);
    endfunction

    function automatic bit [7:0] hue_chan(input int i, input int k);
        longint s;
        s = wave_q30(12 * i + 4 * k * PALETTE_SIZE) * 127 + (longint'(128) <<< 30);
        return 8'(s >>> 30);
    endfunction

    // One step of z = z*z + c with the squares refreshed.
    function automatic void orbit_step(inout longint x, y, x2, y2, input longint cr, ci);
        longint p;
        p  = q40_mul(x, y);
        y  = sat_sum(sat_sum(p, p), ci);
        x  = sat_sum(sat_diff(x2, y2), cr);
        x2 = q40_mul(x, x);
        y2 = q40_mul(y, y);
    endfunction

    function automatic pix_color_t color_pixel(input bit [11:0] col, input bit [11:0] row);
        longint cr, ci, x, y, x2, y2, lx, ly, n, mu, l2;
        longint unsigned lg, l1, idx;
        int per;
        bit cyc;
        bit [23:0] rgb;
        pix_color_t res;
        cr = clamp32(re_start + longint'(col) * re_step) * 4096;
        ci = clamp32(im_top - longint'(row) * im_step) * 4096;
        x = 0; y = 0; x2 = 0; y2 = 0; lx = 0; ly = 0; n = 0; per = 0; cyc = 0; rgb = 0;
        while (sat_sum(x2, y2) <= FOUR_Q40 && n < MAX_ITERATIONS) begin
            orbit_step(x, y, x2, y2, cr, ci);
            if (x == lx && y == ly) begin
                cyc = 1;
                break;
            end
            per++;
            if (per > PERIOD_LEN) begin
                lx = x; ly = y; per = 1;
            end
            n++;
        end
        if (cyc) begin
            n = MAX_ITERATIONS;
        end else if (n < MAX_ITERATIONS) begin
            orbit_step(x, y, x2, y2, cr, ci);
            orbit_step(x, y, x2, y2, cr, ci);
            n += 2;
            lg = log2_q24(sat_sum(x2, y2));
            l1 = lg < (64'd41 << 24) ? (64'd1 << 24) : lg - (64'd40 << 24);
            l2 = longint'(log2_q24(l1) - (64'd24 << 24));
            mu = ((n + 1) <<< 24) + 8871228 - l2;
            if (mu < 0) mu = 0;
            n = mu >>> 24;
        end
        res.in_set = (n == MAX_ITERATIONS);
        if (!res.in_set) begin
            idx = (n * PALETTE_SIZE / MAX_ITERATIONS) % PALETTE_SIZE;
            rgb = hue_rom[idx];
        end
        res.count = n[9:0];
        res.red   = rgb[23:16];
        res.green = rgb[15:8];
        res.blue  = rgb[7:0];
        return res;
    endfunction

    // ---------------- checking ----------------

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: color word %s mismatch: got %0d, expected %0d", $realtime, what, got,
                 want);
        errors++;
    endtask

    // Handshakes, prediction, comparison and the watchdog, all at the rising edge.
    always @(posedge aclk) begin
        pix_color_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        m_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_START_REAL: re_start = longint'(signed'(cfg_data));
                    REG_TOP_IMAG:   im_top   = longint'(signed'(cfg_data));
                    REG_STEP_REAL:  re_step  = longint'(signed'(cfg_data));
                    REG_STEP_IMAG:  im_step  = longint'(signed'(cfg_data));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                color_q.insert(color_q.size(), color_pixel(s_tdata[11:0], s_tdata[23:12]));
                if ($urandom_range(0, 39) == 0) quiet = ~quiet;
            end
            if (m_tvalid && m_tready) begin
                if (color_q.size() == 0) begin
                    report("unexpected", m_tdata[9:0], -1);
                end else begin
                    want = color_q.pop_front();
                    if (m_tdata[9:0] != want.count) report("count", m_tdata[9:0], want.count);
                    if (m_tuser != want.in_set) report("inside", m_tuser, want.in_set);
                    if (m_tdata[17:10] != want.red) report("red", m_tdata[17:10], want.red);
                    if (m_tdata[25:18] != want.green)
                        report("green", m_tdata[25:18], want.green);
                    if (m_tdata[33:26] != want.blue) report("blue", m_tdata[33:26], want.blue);
                    if (m_tdata[39:34] != '0) report("pad", m_tdata[39:34], 0);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Pixel driver: holds a word until taken, then waits its drawn gap.
    always @(negedge aclk) begin
        if (!aresetn || (s_tvalid && !s_fire)) begin
        end else if (s_gap > 0) begin
            s_tvalid <= 1'b0;
            s_gap--;
        end else if (pixel_q.size() > 0) begin
            s_tdata  <= pixel_q.pop_front();
            s_tvalid <= 1'b1;
            s_gap = quiet ? 0 : $urandom_range(0, 18);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Color receiver: random stalls per word, plus one long hold-off.
    always @(negedge aclk) begin
        if (hold_armed) begin
            hold_cnt = LONG_HOLD;
            hold_armed = 0;
        end
        if (m_fire) m_stall = quiet ? 0 : $urandom_range(0, 18);
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------

    task automatic write_reg(input cfg_reg_t idx, input bit [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input bit [31:0] sr, ti, dr, di);
        write_reg(REG_START_REAL, sr);
        write_reg(REG_TOP_IMAG, ti);
        write_reg(REG_STEP_REAL, dr);
        write_reg(REG_STEP_IMAG, di);
    endtask

    // Waits until every pixel is sent and every color has come back.
    task automatic drain();
        while (pixel_q.size() != 0 || s_tvalid || color_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic add_pixel(input int col, input int row);
        pixel_q.insert(pixel_q.size(), {12'(row), 12'(col)});
    endtask

    initial begin
        for (int i = 0; i < PALETTE_SIZE; i++)
            hue_rom[i] = {hue_chan(i, 1), hue_chan(i, 0), hue_chan(i, 2)};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default window: field extremes, alternating bits, a point near the axis.
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(4095, 0);
        add_pixel(0, 4095);
        add_pixel(12'hAAA, 12'h555);
        add_pixel(12'h555, 12'hAAA);
        add_pixel(0, 341);
        add_pixel(100, 300);
        drain();

        // Extreme registers: saturated c, huge modulus, negative smoothed value.
        set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(1, 1);
        add_pixel(4095, 0);
        drain();

        // c = 0 hits the periodicity check at once.
        set_window(0, 0, 0, 0);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        drain();

        // c = -1 settles into an orbit that alternates between 0 and -1.
        set_window(32'hF000_0000, 0, 0, 0);
        add_pixel(7, 9);
        add_pixel(4095, 1);
        drain();

        // Coarse grid over the whole set, a few slow points among them.
        set_window(32'hD800_0000, 32'h1400_0000, 32'h0030_0000, 32'h0030_0000);
        for (int i = 0; i < 30; i++) add_pixel($urandom_range(0, 340), $urandom_range(0, 213));
        drain();

        // Random windows with full range pixels; the first one starts under a
        // long hold-off on the color side so the input backs up.
        for (int ph = 0; ph < 8; ph++) begin
            set_window($urandom, $urandom, $urandom, $urandom);
            if (ph == 0) hold_armed = 1;
            for (int i = 0; i < 68; i++) add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            drain();
        end

        repeat (300) @(posedge aclk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
